// ===== sv/rhsc_pkg.sv =====
// Package: shared constants and pipeline types of the RGB to HSV skin classifier.
`timescale 1ns / 1ps
`default_nettype none

package rhsc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HUE_LOW   = 3'd0,
    REG_HUE_HIGH  = 3'd1,
    REG_SAT_MIN   = 3'd2,
    REG_SAT_MAX   = 3'd3,
    REG_BRIGHT_MIN = 3'd4
  } cfg_reg_t;

  localparam int CfgIdxW = 3;

  // Register reset values
  localparam logic [7:0] HUE_LOW_RST    = 8'd25;
  localparam logic [7:0] HUE_HIGH_RST   = 8'd237;
  localparam logic [7:0] SAT_MIN_RST    = 8'd51;
  localparam logic [7:0] SAT_MAX_RST    = 8'd204;
  localparam logic [7:0] BRIGHT_MIN_RST = 8'd130;

  // One quotient bit per divide stage; both quotients fit in a byte
  localparam int DivSteps = 8;
  localparam int HueNumW  = 11;   // numerator and 6*chroma, up to 1530
  localparam int HueRemW  = 19;   // 255 * numerator
  localparam int SatRemW  = 16;   // 255 * chroma

  // Divisor used where the true one is zero and the dividend is zero
  localparam logic [HueNumW-1:0] HUE_DEN_SAFE = 11'd1;
  localparam logic [7:0]         SAT_DEN_SAFE = 8'd1;

  // Sector selection result, registered after the first stage
  typedef struct packed {
    logic [HueNumW-1:0] hnum;
    logic [HueNumW-1:0] hden;
    logic [7:0]         chroma;
    logic [7:0]         sden;
    logic [7:0]         bright;
  } sector_t;

  // State of both dividers between divide stages
  typedef struct packed {
    logic [HueRemW-1:0] hrem;
    logic [HueNumW-1:0] hden;
    logic [7:0]         hq;
    logic [SatRemW-1:0] srem;
    logic [7:0]         sden;
    logic [7:0]         sq;
    logic [7:0]         bright;
  } div_t;

endpackage

`default_nettype wire

// ===== sv/rhsc_pixel_if.sv =====
// Interface: RGB pixel channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface rhsc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== sv/rhsc_hsv_if.sv =====
// Interface: HSV result channel with skin flag and valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface rhsc_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       is_skin;

  modport source (output valid, hue, saturation, brightness, is_skin, input ready);
  modport sink   (input valid, hue, saturation, brightness, is_skin, output ready);
endinterface

`default_nettype wire

// ===== sv/rhsc_cfg_if.sv =====
// Interface: configuration write channel (register index and data).
`timescale 1ns / 1ps
`default_nettype none

interface rhsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/rgb_to_hsv_skin_classifier_unit.sv =====
// Top level: pipelined RGB to HSV converter with skin classification.
//
// Channels: pixel (sink) carries red, green, blue; result (source) carries
// hue, saturation, brightness and is_skin; cfg (sink) writes the five
// threshold registers by index (0 hue low, 1 hue high, 2 sat min,
// 3 sat max, 4 bright min). Unknown indexes are dropped; cfg is always ready.
// A transferred pixel passes the sector stage, multiply stage, eight divide
// stages and the classify/output register before its result shows on the
// result channel.
// Throughput: one pixel per cycle when not stalled. Both divisions run as
// 8-stage restoring dividers, one quotient bit per stage, so a new pixel can
// enter every cycle unless the pipeline stalls.
// Reset (rst, synchronous, active high): pipeline valid bits clear and
// the thresholds return to 25, 237, 51, 204, 130.
// Stall: when a result waits and the receiver holds ready low, the whole
// pipeline holds and pixel.ready drops; nothing is lost or repeated.
// Thresholds are sampled at the classify stage; write them while idle.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_skin_classifier_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  rhsc_pixel_if.sink   pixel,
  rhsc_hsv_if.source   result,
  rhsc_cfg_if.sink     cfg
);
  import rhsc_pkg::*;

  // Threshold registers
  logic [7:0] hue_low_limit;
  logic [7:0] hue_high_limit;
  logic [7:0] sat_min;
  logic [7:0] sat_max;
  logic [7:0] bright_min;

  // Pipeline registers
  logic    sec_vld;
  sector_t sec;
  logic    div_vld [DivSteps+1];
  div_t    div_st  [DivSteps+1];
  logic    out_vld;
  logic [7:0] out_hue;
  logic [7:0] out_sat;
  logic [7:0] out_bright;
  logic       out_skin;

  logic    adv;
  sector_t sec_next;
  div_t    mul_next;
  logic    skin_next;

  // Advance whenever the output register is free or being drained
  assign adv         = !out_vld || result.ready;
  assign pixel.ready = adv;
  assign cfg.ready   = 1'b1;

  // Accept threshold writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low_limit  <= HUE_LOW_RST;
      hue_high_limit <= HUE_HIGH_RST;
      sat_min        <= SAT_MIN_RST;
      sat_max        <= SAT_MAX_RST;
      bright_min     <= BRIGHT_MIN_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_HUE_LOW:    hue_low_limit  <= cfg.data;
        REG_HUE_HIGH:   hue_high_limit <= cfg.data;
        REG_SAT_MIN:    sat_min        <= cfg.data;
        REG_SAT_MAX:    sat_max        <= cfg.data;
        REG_BRIGHT_MIN: bright_min     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage 1: max, min, chroma, sector numerator and denominator
  always_comb begin
    logic              b_max;
    logic              g_max;
    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [7:0]        c;
    logic [HueNumW-1:0] c_w;
    logic [HueNumW-1:0] r_w;
    logic [HueNumW-1:0] g_w;
    logic [HueNumW-1:0] b_w;
    logic [HueNumW-1:0] six_c;
    logic [HueNumW-1:0] num;

    b_max = (pixel.blue >= pixel.red) && (pixel.blue >= pixel.green);
    g_max = !b_max && (pixel.green >= pixel.red);
    mx = b_max ? pixel.blue : (g_max ? pixel.green : pixel.red);
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn)  mn = pixel.blue;
    c     = mx - mn;
    c_w   = {3'b000, c};
    r_w   = {3'b000, pixel.red};
    g_w   = {3'b000, pixel.green};
    b_w   = {3'b000, pixel.blue};
    six_c = (c_w << 2) + (c_w << 1);

    if (b_max) begin
      num = (c_w << 2) + r_w - g_w;
    end else if (g_max) begin
      num = (c_w << 1) + b_w - r_w;
    end else if (pixel.green >= pixel.blue) begin
      num = g_w - b_w;
    end else begin
      num = six_c + g_w - b_w;
    end

    // Gray pixel gives hue 0, black pixel gives saturation 0
    sec_next.hnum   = (c == 8'd0) ? '0 : num;
    sec_next.hden   = (c == 8'd0) ? HUE_DEN_SAFE : six_c;
    sec_next.chroma = c;
    sec_next.sden   = (mx == 8'd0) ? SAT_DEN_SAFE : mx;
    sec_next.bright = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_vld <= 1'b0;
    end else if (adv) begin
      sec_vld <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec <= sec_next;
    end
  end

  // Stage 2: scale both dividends by 255
  always_comb begin
    mul_next.hrem   = ({8'b0, sec.hnum} << 8) - {8'b0, sec.hnum};
    mul_next.hden   = sec.hden;
    mul_next.hq     = '0;
    mul_next.srem   = {sec.chroma, 8'b0} - {8'b0, sec.chroma};
    mul_next.sden   = sec.sden;
    mul_next.sq     = '0;
    mul_next.bright = sec.bright;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (adv) begin
      div_vld[0] <= sec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_st[0] <= mul_next;
    end
  end

  // Divide stages: one restoring step for each quotient, MSB first
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int Sh = DivSteps - 1 - k;
    div_t step_next;

    always_comb begin
      logic [HueRemW-1:0] h_trial;
      logic [SatRemW-1:0] s_trial;
      logic               h_bit;
      logic               s_bit;

      h_trial = {{(HueRemW-HueNumW){1'b0}}, div_st[k].hden} << Sh;
      s_trial = {{(SatRemW-8){1'b0}}, div_st[k].sden} << Sh;
      h_bit   = div_st[k].hrem >= h_trial;
      s_bit   = div_st[k].srem >= s_trial;

      step_next        = div_st[k];
      step_next.hrem   = h_bit ? div_st[k].hrem - h_trial : div_st[k].hrem;
      step_next.hq     = {div_st[k].hq[6:0], h_bit};
      step_next.srem   = s_bit ? div_st[k].srem - s_trial : div_st[k].srem;
      step_next.sq     = {div_st[k].sq[6:0], s_bit};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[k+1] <= 1'b0;
      end else if (adv) begin
        div_vld[k+1] <= div_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_st[k+1] <= step_next;
      end
    end
  end

  // Classify and register the result
  assign skin_next =
    ((div_st[DivSteps].hq <= hue_low_limit) || (div_st[DivSteps].hq >= hue_high_limit)) &&
    (div_st[DivSteps].sq >= sat_min) && (div_st[DivSteps].sq <= sat_max) &&
    (div_st[DivSteps].bright >= bright_min);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= div_vld[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hue    <= div_st[DivSteps].hq;
      out_sat    <= div_st[DivSteps].sq;
      out_bright <= div_st[DivSteps].bright;
      out_skin   <= skin_next;
    end
  end

  assign result.valid      = out_vld;
  assign result.hue        = out_hue;
  assign result.saturation = out_sat;
  assign result.brightness = out_bright;
  assign result.is_skin    = out_skin;

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !pixel.ready)
    else $error("pixel accepted while result stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.hue != 8'hFF))
    else $error("hue quotient out of range");

  a_black_pixel: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.brightness == 8'd0)) |->
      ((result.saturation == 8'd0) && (result.hue == 8'd0)))
    else $error("black pixel with nonzero hue or saturation");

  a_skin_bright: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.is_skin) |-> (result.brightness >= bright_min))
    else $error("skin flag set below brightness minimum");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

// ===== tb/rgb_to_hsv_skin_classifier_unit_tb.sv =====
// Testbench for the RGB to HSV skin classifier: predicted results against a scoreboard.
`timescale 1ns / 1ps

module rgb_to_hsv_skin_classifier_unit_tb;
  import rhsc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 16;   // pipeline latency plus margin
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES      = 8;
  localparam int PRESSURE_PHASE  = 5;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bright;
    logic       skin;
  } hsv_result_t;

  // Scoreboard: threshold copy, HSV predictor and queue of pending results
  class hsv_scoreboard;
    logic [7:0]  hue_lo;
    logic [7:0]  hue_hi;
    logic [7:0]  sat_lo;
    logic [7:0]  sat_hi;
    logic [7:0]  bright_lo;
    hsv_result_t expected_hsv[$];
    int unsigned pixels_in;
    int unsigned results_checked;
    int unsigned mismatches;

    function new();
      hue_lo          = HUE_LOW_RST;
      hue_hi          = HUE_HIGH_RST;
      sat_lo          = SAT_MIN_RST;
      sat_hi          = SAT_MAX_RST;
      bright_lo       = BRIGHT_MIN_RST;
      pixels_in       = 0;
      results_checked = 0;
      mismatches      = 0;
    endfunction

    // Track a threshold write; unknown indexes change nothing
    function void set_threshold(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      case (idx)
        REG_HUE_LOW:    hue_lo    = val;
        REG_HUE_HIGH:   hue_hi    = val;
        REG_SAT_MIN:    sat_lo    = val;
        REG_SAT_MAX:    sat_hi    = val;
        REG_BRIGHT_MIN: bright_lo = val;
        default: ;
      endcase
    endfunction

    // Convert one pixel to hue, saturation, brightness and skin flag
    function hsv_result_t hsv_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [7:0]  mx;
      logic [7:0]  mn;
      logic [7:0]  chroma;
      logic [15:0] sat_prod;
      logic [10:0] hue_num;
      logic [10:0] hue_den;
      logic [18:0] hue_prod;
      hsv_result_t res;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      chroma = mx - mn;
      res = '0;
      res.bright = mx;
      // black stays at zero saturation
      if (mx != 0) begin
        sat_prod = 16'(255 * chroma);
        res.sat  = 8'(sat_prod / mx);
      end
      // gray stays at zero hue; ties go to blue, then green, then red
      if (chroma != 0) begin
        if (mx == b) begin
          hue_num = 11'(4 * chroma + r - g);
        end else if (mx == g) begin
          hue_num = 11'(2 * chroma + b - r);
        end else if (g >= b) begin
          hue_num = 11'(g - b);
        end else begin
          hue_num = 11'(6 * chroma + g - b);
        end
        hue_den  = 11'(6 * chroma);
        hue_prod = 19'(255 * hue_num);
        res.hue  = 8'(hue_prod / hue_den);
      end
      // limits are taken as written, even when inverted
      res.skin = (res.hue <= hue_lo || res.hue >= hue_hi) &&
                 res.sat >= sat_lo && res.sat <= sat_hi && mx >= bright_lo;
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      expected_hsv.insert(expected_hsv.size(), hsv_of(r, g, b));
      pixels_in++;
    endfunction

    function void check_result(hsv_result_t got);
      hsv_result_t exp_res;
      if (expected_hsv.size() == 0) begin
        $display("%0t ns: result with none pending, got hue %0d sat %0d bright %0d skin %0b",
                 $time, got.hue, got.sat, got.bright, got.skin);
        mismatches++;
        return;
      end
      exp_res = expected_hsv.pop_front();
      results_checked++;
      if (got.hue !== exp_res.hue || got.sat !== exp_res.sat ||
          got.bright !== exp_res.bright || got.skin !== exp_res.skin) begin
        $display({"%0t ns: mismatch, expected hue %0d sat %0d bright %0d skin %0b,",
                  " got hue %0d sat %0d bright %0d skin %0b"},
                 $time, exp_res.hue, exp_res.sat, exp_res.bright, exp_res.skin,
                 got.hue, got.sat, got.bright, got.skin);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_hsv.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rhsc_pixel_if pix_if ();
  rhsc_hsv_if   hsv_if ();
  rhsc_cfg_if   cfg_if ();

  hsv_scoreboard sb = new();

  int unsigned pixel_idle_pct   = 0;
  int unsigned result_stall_pct = 0;
  int unsigned hold_off_len     = 0;

  rgb_to_hsv_skin_classifier_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (hsv_if),
    .cfg    (cfg_if)
  );

  always #4 clk = ~clk;

  // Offer one pixel, idling at random first, and hold it until the transfer
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < pixel_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_pixel(r, g, b);
  endtask

  function automatic logic [7:0] edge_level();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      3:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mix of plain noise, skin tones, tied channels and channel extremes
  task automatic send_random_pixel();
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  swap;
    int unsigned kind;
    kind = $urandom_range(99);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    if (kind < 35) begin
      // keep the noise pixel as drawn
    end else if (kind < 70) begin
      // red leads, green in between, blue lowest; swap for the wrapped hue side
      r = 8'($urandom_range(90, 255));
      g = 8'($urandom_range(r / 4, r));
      b = 8'($urandom_range(0, g));
      if ($urandom_range(1) == 1) begin
        swap = g;
        g = b;
        b = swap;
      end
    end else if (kind < 85) begin
      case ($urandom_range(3))
        0:       g = r;
        1:       b = r;
        2:       b = g;
        default: begin
          g = r;
          b = r;
        end
      endcase
    end else begin
      r = edge_level();
      g = edge_level();
      b = edge_level();
    end
    send_pixel(r, g, b);
  endtask

  // Write one register and hold valid for the next write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_threshold(idx, val);
  endtask

  // Write all five thresholds, then one unused index that must be dropped
  task automatic program_thresholds(input logic [7:0] h_lo, input logic [7:0] h_hi,
                                    input logic [7:0] s_lo, input logic [7:0] s_hi,
                                    input logic [7:0] v_lo);
    logic [CfgIdxW-1:0] spare_idx;
    spare_idx = CfgIdxW'($urandom_range(int'(REG_BRIGHT_MIN) + 1, (1 << CfgIdxW) - 1));
    write_reg(REG_HUE_LOW, h_lo);
    write_reg(REG_HUE_HIGH, h_hi);
    write_reg(REG_SAT_MIN, s_lo);
    write_reg(REG_SAT_MAX, s_hi);
    write_reg(REG_BRIGHT_MIN, v_lo);
    write_reg(spare_idx, 8'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering pixels, wait for every pending result, then let the pipe settle
  task automatic drain_pipeline();
    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: check each transfer and drive ready with stalls and the long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    hsv_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hsv_if.valid && hsv_if.ready)
        sb.check_result('{hue: hsv_if.hue, sat: hsv_if.saturation,
                          bright: hsv_if.brightness, skin: hsv_if.is_skin});
      if (hold_off_len != 0) begin
        hold_left = hold_off_len;
        hold_off_len = 0;
      end
      if (hold_left != 0) begin
        hsv_if.ready <= 1'b0;
        hold_left--;
      end else begin
        hsv_if.ready <= ($urandom_range(99) >= result_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no channel moves a transfer for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_if.valid && pix_if.ready) || (hsv_if.valid && hsv_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transfer for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence: reset, corner pixels, then one phase per threshold setting
  initial begin
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_HUE_LOW;
    cfg_if.data  <= '0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Corner pixels under the reset thresholds, no idling
    send_pixel(8'd0, 8'd0, 8'd0);         // black
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
    send_pixel(8'd1, 8'd1, 8'd1);         // dimmest gray
    send_pixel(8'd255, 8'd0, 8'd0);       // pure red
    send_pixel(8'd0, 8'd255, 8'd0);       // pure green
    send_pixel(8'd0, 8'd0, 8'd255);       // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);     // red and green tie, green wins
    send_pixel(8'd255, 8'd0, 8'd255);     // red and blue tie, blue wins
    send_pixel(8'd0, 8'd255, 8'd255);     // green and blue tie, blue wins
    send_pixel(8'd255, 8'd100, 8'd50);    // red sector, green above blue
    send_pixel(8'd255, 8'd50, 8'd100);    // red sector, blue above green, wrapped side
    send_pixel(8'd255, 8'd0, 8'd1);       // hue just below full turn
    send_pixel(8'd1, 8'd0, 8'd0);         // smallest chroma
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd220, 8'd150, 8'd120);   // typical skin tone
    send_pixel(8'd200, 8'd120, 8'd90);
    send_pixel(8'd129, 8'd90, 8'd60);     // just under the brightness floor
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      drain_pipeline();
      case (phase)
        1: program_thresholds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        2: program_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        3: program_thresholds(8'd200, 8'd30, 8'd200, 8'd40, 8'd100);   // inverted limits
        4: program_thresholds(HUE_LOW_RST, HUE_HIGH_RST, SAT_MIN_RST, SAT_MAX_RST,
                              BRIGHT_MIN_RST);
        7: program_thresholds(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom));
        default: program_thresholds(8'($urandom_range(0, 60)), 8'($urandom_range(180, 255)),
                                    8'($urandom_range(0, 120)), 8'($urandom_range(120, 255)),
                                    8'($urandom_range(0, 200)));
      endcase
      // Flow-control mode of this phase
      case (phase % 4)
        1: begin
          pixel_idle_pct   = 0;
          result_stall_pct = 0;
        end
        2: begin
          pixel_idle_pct   = 63;
          result_stall_pct = 0;
        end
        3: begin
          pixel_idle_pct   = 0;
          result_stall_pct = 63;
        end
        default: begin
          pixel_idle_pct   = 32;
          result_stall_pct = 32;
        end
      endcase
      // Hold the receiver off while pixels keep coming so the pipe backs up
      if (phase == PRESSURE_PHASE) begin
        pixel_idle_pct   = 0;
        result_stall_pct = 0;
        hold_off_len     = HOLD_OFF_CYCLES;
      end
      repeat (ITEMS_PER_PHASE) send_random_pixel();
    end
    drain_pipeline();

    $display("Covered %0d pixels under %0d threshold settings with free flow, idle, stall",
             sb.pixels_in, NUM_PHASES);
    $display("and back-pressure; %0d results checked, %0d mismatches, %0d left pending",
             sb.results_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rhsc_pkg.sv
sv/rhsc_pixel_if.sv
sv/rhsc_hsv_if.sv
sv/rhsc_cfg_if.sv
sv/rgb_to_hsv_skin_classifier_unit.sv
tb/rgb_to_hsv_skin_classifier_unit_tb.sv
